FILE: hdl/jspp_pkg.sv
// Shared types and constants for the JSON stream pretty printer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package jspp_pkg;

  // Byte codes the front end reacts to and the back end emits
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;

  // Field widths
  localparam int DEPTH_W = 4;   // nesting level
  localparam int IND_W   = 6;   // indent characters per break (15 * 4 at most)
  localparam logic [2:0] IND_WIDTH_MAX = 3'd4;

  // Newline modes; anything else emits no newline bytes
  localparam logic [1:0] NL_LF   = 2'd0;
  localparam logic [1:0] NL_CRLF = 2'd1;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_INDENT_CHAR  = 2'd0,
    CFG_INDENT_WIDTH = 2'd1,
    CFG_NEWLINE_MODE = 2'd2
  } cfg_idx_t;

  // Live configuration seen by the back end
  typedef struct packed {
    logic [7:0] indent_char;
    logic [2:0] indent_width;
    logic [1:0] newline_mode;
  } cfg_t;

  // One classified request from front to back
  typedef struct packed {
    logic [7:0]         ch;      // byte to emit after any break
    logic               brk;     // line break before the byte
    logic               space;   // trailing space (colon)
    logic [DEPTH_W-1:0] bdepth;  // indent level of the break
  } cmd_t;

  // Back end sequencer states
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_CR,
    BK_LF,
    BK_IND,
    BK_CHAR,
    BK_SPACE
  } bk_state_t;

endpackage

FILE: hdl/jspp_front.sv
// Front end: takes input bytes, tracks string/escape/nesting state and
// classifies each byte into a request for the back end. Uses jspp_pkg.
`timescale 1ns / 1ps
module jspp_front #(
  parameter int MAX_DEPTH = 15
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  logic [7:0]       in_tdata,
  input  logic             q_full,
  output logic             in_tready,
  output logic             q_push,
  output jspp_pkg::cmd_t   q_wdata
);
  import jspp_pkg::*;

  logic [DEPTH_W-1:0] depth_r, depth_nxt;
  logic               pend_r, pend_nxt;
  logic               instr_r, instr_nxt;
  logic               esc_r, esc_nxt;
  cmd_t               cmd;

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;
  assign q_wdata   = cmd;

  // Classify the byte and work out the next parser state
  always_comb begin
    depth_nxt  = depth_r;
    pend_nxt   = pend_r;
    instr_nxt  = instr_r;
    esc_nxt    = esc_r;
    cmd.ch     = in_tdata;
    cmd.brk    = 1'b0;
    cmd.space  = 1'b0;
    cmd.bdepth = depth_r;
    if (esc_r) begin
      esc_nxt = 1'b0;
    end else if (instr_r) begin
      if (in_tdata == CH_BSLASH) begin
        esc_nxt = 1'b1;
      end else if (in_tdata == CH_QUOTE) begin
        instr_nxt = 1'b0;
      end
    end else begin
      unique case (in_tdata) inside
        CH_LBRACE, CH_LBRACK: begin
          cmd.brk = pend_r;
          if (depth_r < DEPTH_W'(MAX_DEPTH)) begin
            depth_nxt = depth_r + 1'b1;
          end
          pend_nxt = 1'b1;
        end
        CH_RBRACE, CH_RBRACK: begin
          // break is indented at the level after the close
          if (depth_r != '0) begin
            depth_nxt = depth_r - 1'b1;
          end
          cmd.bdepth = depth_nxt;
          cmd.brk    = !pend_r;
          pend_nxt   = 1'b0;
        end
        CH_COMMA: begin
          pend_nxt = 1'b1;
        end
        CH_QUOTE: begin
          cmd.brk   = pend_r;
          pend_nxt  = 1'b0;
          instr_nxt = 1'b1;
        end
        CH_COLON: begin
          cmd.space = 1'b1;
        end
        default: begin
          cmd.brk  = pend_r;
          pend_nxt = 1'b0;
        end
      endcase
    end
  end

  // Parser state, updated on each accepted byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
      pend_r  <= 1'b0;
      instr_r <= 1'b0;
      esc_r   <= 1'b0;
    end else if (q_push) begin
      depth_r <= depth_nxt;
      pend_r  <= pend_nxt;
      instr_r <= instr_nxt;
      esc_r   <= esc_nxt;
    end
  end

  a_depth_sat: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= DEPTH_W'(MAX_DEPTH))
    else $error("nesting depth above MAX_DEPTH");

  a_esc_in_str: assert property (@(posedge clk) disable iff (!rst_n)
    esc_r |-> instr_r)
    else $error("escape flag set outside a string");

endmodule

FILE: hdl/jspp_fifo.sv
// Short request queue between front and back end.
// Holds jspp_pkg::cmd_t entries in registers.
`timescale 1ns / 1ps
module jspp_fifo #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  jspp_pkg::cmd_t wdata,
  input  logic           pop,
  output jspp_pkg::cmd_t rdata,
  output logic           full,
  output logic           empty
);
  import jspp_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          mem [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == CW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem[rd_ptr_r];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

  a_no_over: assert property (@(posedge clk) disable iff (!rst_n)
    (full && !pop) |=> (cnt_r == CW'(DEPTH)))
    else $error("queue count moved while full without a pop");

endmodule

FILE: hdl/jspp_back.sv
// Back end: turns queued requests into output bytes (newline, indent run,
// the byte itself, optional space) through a registered output. Uses jspp_pkg.
`timescale 1ns / 1ps
module jspp_back (
  input  logic           clk,
  input  logic           rst_n,
  input  jspp_pkg::cfg_t cfg,
  input  logic           q_empty,
  input  jspp_pkg::cmd_t q_rdata,
  output logic           q_pop,
  input  logic           out_tready,
  output logic           out_tvalid,
  output logic [7:0]     out_tdata,
  output logic           out_tlast
);
  import jspp_pkg::*;

  bk_state_t        st_r, st_nxt;
  cmd_t             cmd_r, cmd_nxt;
  logic [IND_W-1:0] ind_r, ind_nxt;
  logic             ovld_r, ovld_nxt;
  logic [7:0]       obyte_r;
  logic             olast_r;

  logic             emit;
  logic [7:0]       ebyte;
  logic             elast;
  logic [2:0]       wclamp;
  logic [IND_W-1:0] ind_start;

  // Indent characters for a break: level times clamped width (60 at most)
  assign wclamp    = (cfg.indent_width > IND_WIDTH_MAX) ? IND_WIDTH_MAX : cfg.indent_width;
  assign ind_start = IND_W'(q_rdata.bdepth) * IND_W'(wclamp);

  // Output decode per state
  always_comb begin
    q_pop = 1'b0;
    emit  = 1'b0;
    ebyte = cmd_r.ch;
    elast = 1'b0;
    unique case (st_r)
      BK_IDLE: begin
        q_pop = !q_empty;
      end
      BK_CR: begin
        emit  = !ovld_r || out_tready;
        ebyte = CH_CR;
      end
      BK_LF: begin
        emit  = !ovld_r || out_tready;
        ebyte = CH_LF;
      end
      BK_IND: begin
        emit  = !ovld_r || out_tready;
        ebyte = cfg.indent_char;
      end
      BK_CHAR: begin
        emit  = !ovld_r || out_tready;
        ebyte = cmd_r.ch;
        elast = !cmd_r.space;
      end
      BK_SPACE: begin
        emit  = !ovld_r || out_tready;
        ebyte = CH_SPACE;
        elast = 1'b1;
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  // Sequencer next state
  always_comb begin
    st_nxt  = st_r;
    cmd_nxt = cmd_r;
    ind_nxt = ind_r;
    unique case (st_r)
      BK_IDLE: begin
        if (!q_empty) begin
          cmd_nxt = q_rdata;
          ind_nxt = ind_start;
          if (!q_rdata.brk) begin
            st_nxt = BK_CHAR;
          end else if (cfg.newline_mode == NL_LF) begin
            st_nxt = BK_LF;
          end else if (cfg.newline_mode == NL_CRLF) begin
            st_nxt = BK_CR;
          end else if (ind_start != '0) begin
            st_nxt = BK_IND;
          end else begin
            st_nxt = BK_CHAR;
          end
        end
      end
      BK_CR: begin
        if (emit) begin
          st_nxt = BK_LF;
        end
      end
      BK_LF: begin
        if (emit) begin
          st_nxt = (ind_r != '0) ? BK_IND : BK_CHAR;
        end
      end
      BK_IND: begin
        if (emit) begin
          ind_nxt = ind_r - 1'b1;
          if (ind_r == IND_W'(1)) begin
            st_nxt = BK_CHAR;
          end
        end
      end
      BK_CHAR: begin
        if (emit) begin
          st_nxt = cmd_r.space ? BK_SPACE : BK_IDLE;
        end
      end
      BK_SPACE: begin
        if (emit) begin
          st_nxt = BK_IDLE;
        end
      end
      default: begin
        st_nxt = BK_IDLE;
      end
    endcase
  end

  // Output register: loads when empty or being drained
  always_comb begin
    if (emit) begin
      ovld_nxt = 1'b1;
    end else if (out_tready) begin
      ovld_nxt = 1'b0;
    end else begin
      ovld_nxt = ovld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= BK_IDLE;
      ovld_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      ovld_r <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    ind_r <= ind_nxt;
    if (emit) begin
      obyte_r <= ebyte;
      olast_r <= elast;
    end
  end

  assign out_tvalid = ovld_r;
  assign out_tdata  = obyte_r;
  assign out_tlast  = olast_r;

  a_ind_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == BK_IND) |-> (ind_r != '0))
    else $error("indent run entered with zero count");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && elast) |=> (st_r == BK_IDLE))
    else $error("sequencer not idle after final byte of a request");

endmodule

FILE: hdl/json_stream_pretty_printer.sv
// Top level of the JSON stream pretty printer: configuration registers,
// front end, request queue and back end. Uses jspp_pkg and all jspp_* modules.
//
//  Group   Dir  Carries
//  in_*    in   compact JSON byte (tdata[7:0] = in_byte)
//  out_*   out  formatted byte (tdata[7:0] = out_byte), tlast = last of its input
//  cfg_*   in   register write: 0 indent_char, 1 indent_width, 2 newline_mode
//
// The back end takes one request at a time and sends its bytes: the byte
// alone for a plain byte, the byte and a space for a colon, and newline bytes,
// depth * min(indent_width, 4) indent characters and the byte after a break.
// The front end runs ahead by up to FIFO_DEPTH requests; in_tready drops
// when the queue is full, and out_tready low holds the back end in place.
// Reset is synchronous (rst_n low): parser state, queue and output clear,
// configuration returns to indent_char 32, indent_width 2, LF newline.
`timescale 1ns / 1ps
module json_stream_pretty_printer #(
  parameter int MAX_DEPTH  = 15,
  parameter int FIFO_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,    // [7:0] in_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,   // [7:0] out_byte
  output logic       out_tlast,
  input  logic       cfg_we,
  input  logic [1:0] cfg_addr,
  input  logic [7:0] cfg_wdata
);
  import jspp_pkg::*;

  cfg_t cfg_r;
  cmd_t q_wdata;
  cmd_t q_rdata;
  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.indent_char  <= CH_SPACE;
      cfg_r.indent_width <= 3'd2;
      cfg_r.newline_mode <= NL_LF;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_INDENT_CHAR:  cfg_r.indent_char  <= cfg_wdata;
        CFG_INDENT_WIDTH: cfg_r.indent_width <= cfg_wdata[2:0];
        CFG_NEWLINE_MODE: cfg_r.newline_mode <= cfg_wdata[1:0];
        default: begin
          cfg_r <= cfg_r;
        end
      endcase
    end
  end

  jspp_front #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .in_tready (in_tready),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  jspp_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  jspp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_empty    (q_empty),
    .q_rdata    (q_rdata),
    .q_pop      (q_pop),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
